// ===== design/rufc_pkg.sv =====
// ---------------------------------------------------------------------------
// rufc_pkg: shared types and constants
// Action codes, stream widths and the command/status bundles between the
// controller and the datapath of the RS485 UART buffer controller.
// ---------------------------------------------------------------------------
package rufc_pkg;

  localparam int ACT_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 6;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ACT_W-1:0] ACT_HOST_WRITE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HOST_READ  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_IRQ        = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR_TX   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR_RX   = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load_item;  // capture the incoming word
    logic exec;       // pointer/flag update and RAM access
    logic load_out;   // move result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register empty or draining this cycle
  } dp_status_t;

endpackage

// ===== design/rs485_uart_fifo_controller.sv =====
// ---------------------------------------------------------------------------
// rs485_uart_fifo_controller: RS485 UART byte ring buffers
// Transmit and receive byte rings with TXE/TC interrupt enables and the
// RS485 driver-enable line.
//
// Input stream (s_axis): one word per host write, host read, interrupt
// event or ring clear. tuser carries the action code and the interrupt
// flags, tdata the byte, tlast marks the final byte of a send.
// Output stream (m_axis): exactly one word per input word, carrying the
// byte sent to the line, the byte popped by a host read, and the driver
// enable and interrupt enables after the update.
// Flow: an accepted word gets its update with RAM access, then the output
// register is loaded from the registered RAM read. The single-word
// sequencer around the registered RAMs takes no new word until the current
// one has been loaded into the output register.
// Reset: all pointers, enables and driver enable go to zero; no clearing
// pass, buffer contents are undefined until written.
// Stall: while a result sits in the output register the next word is still
// accepted; it waits in the result stage until the output register frees.
// ---------------------------------------------------------------------------
module rs485_uart_fifo_controller #(
  parameter int TX_DEPTH = 128,
  parameter int RX_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] data
  input  logic [rufc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] action, [3] rx_flag, [4] txe_flag, [5] tc_flag
  input  logic [rufc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
  // [18] driver_enable, [19] txe_irq_on, [20] tc_irq_on, [23:21] zero
  output logic [rufc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import rufc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rufc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  rufc_datapath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_tdata      (s_axis_tdata),
    .in_tuser      (s_axis_tuser),
    .in_tlast      (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== design/rufc_ram.sv =====
// ---------------------------------------------------------------------------
// rufc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module rufc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rufc_ctrl.sv =====
// ---------------------------------------------------------------------------
// rufc_ctrl: sequencing state machine
// Takes one word, runs the update step, then hands the result to the
// output register once it is free.
// ---------------------------------------------------------------------------
module rufc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  rufc_pkg::dp_status_t   status,
  output rufc_pkg::ctrl_cmd_t    cmd
);
  import rufc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // RAM read data is valid here
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_EXEC))
    else $error("accepted word did not start execution");

  a_exec_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> (state == ST_DONE))
    else $error("execution cycle not followed by result stage");

endmodule

// ===== design/rufc_datapath.sv =====
// ---------------------------------------------------------------------------
// rufc_datapath: ring pointers, IRQ enables, buffer RAMs, output register
// Holds both byte rings and performs one update per exec command.
// ---------------------------------------------------------------------------
module rufc_datapath #(
  parameter int TX_DEPTH = 128,
  parameter int RX_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rufc_pkg::ctrl_cmd_t                 cmd,
  output rufc_pkg::dp_status_t                status,
  input  logic [rufc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [rufc_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                in_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rufc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import rufc_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  // captured word
  logic [ACT_W-1:0]  act;
  logic [BYTE_W-1:0] data;
  logic              send_last;
  logic              rx_flag;
  logic              txe_flag;
  logic              tc_flag;

  logic [TX_AW-1:0] tx_head;
  logic [TX_AW-1:0] tx_tail;
  logic [RX_AW-1:0] rx_head;
  logic [RX_AW-1:0] rx_tail;
  logic             txe_en;
  logic             tc_en;
  logic             dir_tx;
  logic             line_go;
  logic             read_go;

  logic [BYTE_W-1:0] tx_rdata;
  logic [BYTE_W-1:0] rx_rdata;

  logic tx_empty;
  logic rx_empty;
  logic host_wr;
  logic host_rd;
  logic rx_wr;
  logic txe_act;
  logic tc_act;
  logic send;

  logic [TX_AW-1:0] tx_head_inc;
  logic [TX_AW-1:0] tx_tail_inc;
  logic [RX_AW-1:0] rx_head_inc;
  logic [RX_AW-1:0] rx_tail_inc;

  always_comb begin
    tx_empty = (tx_tail == tx_head);
    rx_empty = (rx_tail == rx_head);
    host_wr  = (act == ACT_HOST_WRITE);
    host_rd  = (act == ACT_HOST_READ) && !rx_empty;
    rx_wr    = (act == ACT_IRQ) && rx_flag;
    // TXE has priority; TC is only looked at when TXE does not act
    txe_act  = (act == ACT_IRQ) && txe_flag && txe_en;
    tc_act   = (act == ACT_IRQ) && !txe_act && tc_flag && tc_en;
    send     = (txe_act || tc_act) && !tx_empty;

    tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
    tx_tail_inc = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
    rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
    rx_tail_inc = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      data      <= in_tdata[BYTE_W-1:0];
      act       <= in_tuser[ACT_W-1:0];
      rx_flag   <= in_tuser[3];
      txe_flag  <= in_tuser[4];
      tc_flag   <= in_tuser[5];
      send_last <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head <= '0;
      tx_tail <= '0;
      rx_head <= '0;
      rx_tail <= '0;
      txe_en  <= 1'b0;
      tc_en   <= 1'b0;
      dir_tx  <= 1'b0;
      line_go <= 1'b0;
      read_go <= 1'b0;
    end else if (cmd.exec) begin
      line_go <= send;
      read_go <= host_rd;
      if (host_wr) begin
        tx_head <= tx_head_inc;
        if (send_last) begin
          dir_tx <= 1'b1;
          txe_en <= 1'b1;
        end
      end
      if (host_rd) begin
        rx_tail <= rx_tail_inc;
      end
      if (rx_wr) begin
        rx_head <= rx_head_inc;
      end
      if (send) begin
        tx_tail <= tx_tail_inc;
      end
      if (txe_act && tx_empty) begin
        txe_en <= 1'b0;
        tc_en  <= 1'b1;
      end
      if (tc_act && tx_empty) begin
        tc_en  <= 1'b0;
        dir_tx <= 1'b0;
      end
      if (act == ACT_CLEAR_TX) begin
        tx_head <= '0;
        tx_tail <= '0;
      end
      if (act == ACT_CLEAR_RX) begin
        rx_head <= '0;
        rx_tail <= '0;
      end
    end
  end

  rufc_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (cmd.exec && host_wr),
    .waddr (tx_head),
    .wdata (data),
    .re    (cmd.exec && send),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  rufc_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.exec && rx_wr),
    .waddr (rx_head),
    .wdata (data),
    .re    (cmd.exec && host_rd),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= {3'b000, tc_en, txe_en, dir_tx,
                       read_go ? rx_rdata : {BYTE_W{1'b0}}, read_go,
                       line_go ? tx_rdata : {BYTE_W{1'b0}}, line_go};
    end
  end

  assign status.out_free = !m_axis_tvalid || m_axis_tready;

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9]))
    else $error("line byte and read byte in the same result");

  a_clear_tx: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && act == ACT_CLEAR_TX) |=> (tx_head == '0 && tx_tail == '0))
    else $error("tx ring pointers not cleared");

  a_send_advances: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && send) |=> (tx_tail != $past(tx_tail)))
    else $error("tx read pointer did not advance on send");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !cmd.load_out)
    else $error("result loaded over a stalled word");

endmodule

// ===== bench/rufc_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rufc_checker: word-level checker for the RS485 UART ring controller
// Watches both stream channels, keeps its own copy of the transmit and
// receive rings, pointers, interrupt enables and driver enable, predicts
// the status word for every accepted input word and compares each output
// word against the oldest prediction.
// ---------------------------------------------------------------------------
module rufc_checker #(
  parameter int TX_DEPTH = 128,
  parameter int RX_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // [7:0] data
  input  logic [rufc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] action, [3] rx_flag, [4] txe_flag, [5] tc_flag
  input  logic [rufc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
  // [18] driver_enable, [19] txe_irq_on, [20] tc_irq_on, [23:21] zero
  input  logic [rufc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output int                                fail_count,
  output int                                pending,
  output int                                line_bytes,
  output int                                host_bytes
);
  import rufc_pkg::*;

  // same bit order as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic              tc_on;
    logic              txe_on;
    logic              drv_en;
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_ok;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_ok;
  } line_status_t;

  logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
  logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
  int                tx_wr, tx_rd, rx_wr, rx_rd;
  logic              txe_en, tc_en, drv_en;
  line_status_t      status_q[$];
  int                words_checked;

  function automatic int bump(int p, int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40)
      $display("[%0t] ERROR word %0d: %s", $realtime, words_checked, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic predict_word(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b,
                              input logic last, input logic rxf, input logic txef,
                              input logic tcf, output line_status_t st);
    st = '0;
    case (act)
      ACT_HOST_WRITE: begin
        tx_ring[tx_wr] = b;
        tx_wr = bump(tx_wr, TX_DEPTH);
        if (last) begin
          drv_en = 1'b1;
          txe_en = 1'b1;
        end
      end
      ACT_HOST_READ: begin
        if (rx_rd != rx_wr) begin
          st.rd_ok   = 1'b1;
          st.rd_byte = rx_ring[rx_rd];
          rx_rd = bump(rx_rd, RX_DEPTH);
        end
      end
      ACT_IRQ: begin
        if (rxf) begin
          rx_ring[rx_wr] = b;
          rx_wr = bump(rx_wr, RX_DEPTH);
        end
        // TXE wins; TC only looked at when TXE did not act
        if (txef && txe_en) begin
          if (tx_rd == tx_wr) begin
            txe_en = 1'b0;
            tc_en  = 1'b1;
          end else begin
            st.tx_ok   = 1'b1;
            st.tx_byte = tx_ring[tx_rd];
            tx_rd = bump(tx_rd, TX_DEPTH);
          end
        end else if (tcf && tc_en) begin
          if (tx_rd == tx_wr) begin
            tc_en  = 1'b0;
            drv_en = 1'b0;
          end else begin
            st.tx_ok   = 1'b1;
            st.tx_byte = tx_ring[tx_rd];
            tx_rd = bump(tx_rd, TX_DEPTH);
          end
        end
      end
      ACT_CLEAR_TX: begin
        tx_wr = 0;
        tx_rd = 0;
      end
      ACT_CLEAR_RX: begin
        rx_wr = 0;
        rx_rd = 0;
      end
      default: ;
    endcase
    st.drv_en = drv_en;
    st.txe_on = txe_en;
    st.tc_on  = tc_en;
  endtask

  always @(posedge clk) begin : watch
    line_status_t got, want;
    if (rst) begin
      tx_wr = 0;
      tx_rd = 0;
      rx_wr = 0;
      rx_rd = 0;
      txe_en = 1'b0;
      tc_en  = 1'b0;
      drv_en = 1'b0;
      status_q.delete();
      fail_count = 0;
      words_checked = 0;
      line_bytes = 0;
      host_bytes = 0;
    end else begin
      // output side first: a word accepted this edge cannot answer this edge's input
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output word 0x%06h", m_axis_tdata));
        end else begin
          want = status_q.pop_front();
          check_field("line_valid", got.tx_ok, want.tx_ok);
          check_field("line_byte", got.tx_byte, want.tx_byte);
          check_field("read_valid", got.rd_ok, want.rd_ok);
          check_field("read_byte", got.rd_byte, want.rd_byte);
          check_field("driver_enable", got.drv_en, want.drv_en);
          check_field("txe_irq_on", got.txe_on, want.txe_on);
          check_field("tc_irq_on", got.tc_on, want.tc_on);
          check_field("pad", got.pad, want.pad);
          if (want.tx_ok) line_bytes++;
          if (want.rd_ok) host_bytes++;
        end
        words_checked++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(s_axis_tuser[ACT_W-1:0], s_axis_tdata[BYTE_W-1:0], s_axis_tlast,
                     s_axis_tuser[3], s_axis_tuser[4], s_axis_tuser[5], want);
        status_q.push_back(want);
      end
    end
    pending = status_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the RS485 UART ring controller
// Drives host writes, host reads, interrupt events and ring clears into the
// input stream, first a directed walk through the transmit/receive protocol
// and then randomized sends, receive bursts, noise and ring overflows, with
// random gaps and output stalls. The checker module does the comparison.
// ---------------------------------------------------------------------------
module tb_top;
  import rufc_pkg::*;

  localparam int HOLD_CYCLES = 120;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // [2:0] action, [3] rx, [4] txe, [5] tc
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // see checker for field order

  int   fail_count, pending, line_bytes, host_bytes;
  int   word_count, n_write, n_read, n_irq, n_clear, n_other;
  logic calm, rush, hold_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rs485_uart_fifo_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rufc_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .line_bytes    (line_bytes),
    .host_bytes    (host_bytes)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_word(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b,
                          input logic last, input logic rxf, input logic txef,
                          input logic tcf);
    if (!calm && !rush && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tdata  <= b;
    s_axis_tuser  <= {tcf, txef, rxf, act};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    word_count++;
    case (act)
      ACT_HOST_WRITE: n_write++;
      ACT_HOST_READ:  n_read++;
      ACT_IRQ:        n_irq++;
      ACT_CLEAR_TX, ACT_CLEAR_RX: n_clear++;
      default:        n_other++;
    endcase
  endtask

  // random word of any action, every field random
  task automatic put_noise();
    put_word(ACT_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
             1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // receiver: random ready/stall bursts, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin
    #4_800_000;
    $display("timeout with %0d words outstanding", pending);
    $display("rs485_uart_fifo_controller: mismatch");
    $finish;
  end

  initial begin
    int n;
    bit hold_done, pause_done, tx_ovf_done, rx_ovf_done;
    calm = 1'b0;
    rush = 1'b0;
    hold_req = 1'b0;
    word_count = 0;
    n_write = 0;
    n_read = 0;
    n_irq = 0;
    n_clear = 0;
    n_other = 0;
    hold_done = 0;
    pause_done = 0;
    tx_ovf_done = 0;
    rx_ovf_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk: empty read, masked flags, receive and pop extremes
    put_word(ACT_HOST_READ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    put_word(ACT_IRQ,        8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
    put_word(ACT_HOST_READ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_HOST_READ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_HOST_READ,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    // three-byte send, TXE drains it, TXE+TC together: TXE wins
    put_word(ACT_HOST_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_HOST_WRITE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    put_word(ACT_HOST_WRITE, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    put_word(ACT_IRQ,        8'h3C, 1'b0, 1'b1, 1'b1, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    // TC while a byte is still queued sends it and stays enabled
    put_word(ACT_HOST_WRITE, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    // clears keep the enables and driver enable
    put_word(ACT_HOST_WRITE, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0);
    put_word(ACT_CLEAR_TX,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    put_word(ACT_IRQ,        8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    put_word(ACT_CLEAR_RX,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    put_word(ACT_HOST_READ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    // unused action codes
    put_word(3'd5, 8'hC3, 1'b1, 1'b1, 1'b1, 1'b1);
    put_word(3'd7, 8'h96, 1'b0, 1'b1, 1'b1, 1'b1);

    while (word_count < 1000) begin
      if (word_count >= 880) calm = 1'b1;

      if (!hold_done && word_count >= 300) begin
        // output held off while words keep coming: fills the block
        hold_done = 1;
        hold_req = 1'b1;
        rush = 1'b1;
        repeat (30) put_noise();
        rush = 1'b0;
      end

      if (!pause_done && word_count >= 500) begin
        pause_done = 1;
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end

      if (!tx_ovf_done && word_count >= 600) begin
        // one full lap plus two: head overtakes tail
        tx_ovf_done = 1;
        for (int i = 0; i < 130; i++)
          put_word(ACT_HOST_WRITE, BYTE_W'($urandom_range(0, 255)), 1'(i == 129),
                   1'($urandom), 1'($urandom), 1'($urandom));
        repeat (4) put_word(ACT_IRQ, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
      end

      if (!rx_ovf_done && word_count >= 720) begin
        rx_ovf_done = 1;
        for (int i = 0; i < 130; i++)
          put_word(ACT_IRQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom), 1'b1,
                   1'b0, 1'b0);
        repeat (4) put_word(ACT_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // well-formed send: bytes, last marks the end, then TXE/TC events
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            put_word(ACT_HOST_WRITE, BYTE_W'($urandom_range(0, 255)), 1'(i == n - 1),
                     1'($urandom), 1'($urandom), 1'($urandom));
          for (int i = 0; i <= n; i++)
            put_word(ACT_IRQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom),
                     1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 5) != 0),
                     1'($urandom));
          put_word(ACT_IRQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom),
                   1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 3) == 0), 1'b1);
        end
        5, 6: begin
          // receive burst, then pop about as many
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            put_word(ACT_IRQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom), 1'b1,
                     1'($urandom), 1'($urandom));
          n = n + $urandom_range(0, 2) - 1;
          for (int i = 0; i < n; i++)
            put_word(ACT_HOST_READ, BYTE_W'($urandom_range(0, 255)), 1'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom));
        end
        7: repeat ($urandom_range(1, 4)) put_noise();
        8: put_word($urandom_range(0, 1) ? ACT_CLEAR_TX : ACT_CLEAR_RX,
                    BYTE_W'($urandom_range(0, 255)), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom));
        default: put_word(ACT_HOST_READ, BYTE_W'($urandom_range(0, 255)), 1'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom));
      endcase
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);

    $display("%0d words in: %0d writes, %0d reads, %0d irq events, %0d clears, %0d unused",
             word_count, n_write, n_read, n_irq, n_clear, n_other);
    $display("%0d bytes to the line, %0d bytes to the host; overflow laps, hold-off, drain",
             line_bytes, host_bytes);
    if (fail_count == 0)
      $display("rs485_uart_fifo_controller: match");
    else
      $display("rs485_uart_fifo_controller: mismatch");
    $finish;
  end

endmodule
